// File: sv/traffic_message_group_decoder_unit_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef TRAFFIC_MESSAGE_GROUP_DECODER_UNIT_DEFINES_SVH
`define TRAFFIC_MESSAGE_GROUP_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TMGD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define TMGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tmgd_pkg.sv
`timescale 1ns / 1ps
package tmgd_pkg;

    typedef enum logic [3:0] {
        KIND_IGNORED  = 4'd0,
        KIND_SINGLE   = 4'd1,
        KIND_START    = 4'd2,
        KIND_CONTENT  = 4'd3,
        KIND_FINAL    = 4'd4,
        KIND_RESET    = 4'd5,
        KIND_NAME     = 4'd6,
        KIND_SYSTEM   = 4'd7,
        KIND_ENC_ONLY = 4'd8
    } t_kind;

    // system message variants (C bits 15..14)
    localparam logic [1:0] SYS_VAR_TABLE   = 2'd0;
    localparam logic [1:0] SYS_VAR_SERVICE = 2'd1;

    // tuning addresses of the provider name halves
    localparam logic [3:0] TUNE_NAME_FIRST = 4'd4;
    localparam logic [3:0] TUNE_NAME_LAST  = 4'd5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;

    typedef struct packed {
        logic [2:0] expected_part;
        logic [2:0] continuity_index;
        logic [2:0] total_parts;
        logic [1:0] name_half_mask;
        logic [5:0] table_number;
        logic [5:0] encrypted_table_number;
        logic [5:0] service_id;
        logic [4:0] encryption_id;
        logic [5:0] afi_mode_scope;
    } t_state;

    typedef struct packed {
        t_kind        event_kind;
        logic         encryption_updated;
        logic         diversion;
        logic         direction;
        logic [2:0]   extent;
        logic [10:0]  event_code;
        logic [15:0]  location;
        logic [2:0]   duration;
        logic [31:0]  payload;
        logic [1:0]   name_halves;
        logic [28:0]  service_info;
    } t_result;

endpackage

// File: sv/traffic_message_group_decoder_unit.sv
`timescale 1ns / 1ps
// Traffic message group decoder.
// Input stream: one request per traffic group (tuser = 0, blocks B/C/D in
// tdata) or per system message (tuser = 1, word in the C slot). Every
// accepted request yields exactly one result request on the output stream,
// tuser carrying the event kind and tdata the decoded fields.
// Each request passes from the input register through decode into the result
// register. Throughput: one request per cycle while the receiver takes results;
// the single decode pass and the state registers that it updates set that.
// Reassembly and admin state are updated when a request moves from the input
// register into the result register, so results keep input order.
// Reset (i_rst_n low, synchronous) empties both registers and clears all
// reassembly, name and service state to zero.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, after which s_axis_tready drops until the
// result is taken. No request is lost or repeated.
`include "traffic_message_group_decoder_unit_defines.svh"

module traffic_message_group_decoder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: group_b[15:0], group_c[31:16], group_d[47:32]
    input  logic [47:0]  s_axis_tdata,
    // tuser: func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: encryption_updated[0], diversion[1], direction[2], extent[5:3],
    // event_code[16:6], location[32:17], duration[35:33], payload[67:36],
    // name_halves[69:68], service_info[98:70], zero pad[103:99]
    output logic [103:0] m_axis_tdata,
    // tuser: event_kind
    output logic [3:0]   m_axis_tuser
);

    // input register
    logic                   r_in_valid;
    logic                   r_in_func;
    logic [47:0]            r_in_data;
    // result register
    logic                   r_out_valid;
    tmgd_pkg::t_result      r_out;
    // decoder state
    tmgd_pkg::t_state       r_state;

    tmgd_pkg::t_state       n_state;
    tmgd_pkg::t_result      n_out;
    logic                   w_advance;
    logic                   w_in_take;

    // result register free or emptying this cycle
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    tmgd_decode u_decode (
        .i_state   (r_state),
        .i_func    (r_in_func),
        .i_group_b (r_in_data[15:0]),
        .i_group_c (r_in_data[31:16]),
        .i_group_d (r_in_data[47:32]),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_func <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_kind;
    assign m_axis_tdata  = {5'd0, r_out.service_info, r_out.name_halves,
                            r_out.payload, r_out.duration, r_out.location,
                            r_out.event_code, r_out.extent, r_out.direction,
                            r_out.diversion, r_out.encryption_updated};

    `TMGD_ASSERT_NOW(a_part_below_total, (r_state.total_parts != 3'd0) && (r_state.expected_part != 3'd0), r_state.expected_part < r_state.total_parts, "expected part reached part count")
    `TMGD_ASSERT_NEXT(a_final_clears, w_advance && (n_out.event_kind == tmgd_pkg::KIND_FINAL), r_state.expected_part == 3'd0, "final content left reassembly open")
    `TMGD_ASSERT_NOW(a_full_stall, r_in_valid && r_out_valid && !m_axis_tready, !s_axis_tready, "request taken while both stages full")
    `TMGD_ASSERT_NOW(a_name_mask_sync, r_out_valid, r_out.name_halves == r_state.name_half_mask, "shown name halves differ from state")

endmodule

// File: sv/tmgd_decode.sv
`timescale 1ns / 1ps
// Decodes one group against the current reassembly/admin state.
module tmgd_decode (
    input  tmgd_pkg::t_state  i_state,
    input  logic              i_func,
    input  logic [15:0]       i_group_b,
    input  logic [15:0]       i_group_c,
    input  logic [15:0]       i_group_d,
    output tmgd_pkg::t_state  o_state,
    output tmgd_pkg::t_result o_result
);

    tmgd_pkg::t_state  n_st;
    tmgd_pkg::t_result res;
    logic              enc_grp;
    logic              single_grp;
    logic              first_grp;
    logic              second_grp;
    logic [1:0]        gsi;
    logic [2:0]        ci;
    logic [2:0]        tot;
    logic [3:0]        part_sum;

    assign single_grp = i_group_b[3];
    assign ci         = i_group_b[2:0];
    assign first_grp  = i_group_c[15];
    assign second_grp = i_group_c[14];
    assign gsi        = i_group_c[13:12];
    assign enc_grp    = (i_group_b[4:0] == 5'd0) && (i_group_c[15:13] == 3'd0);

    // part count from the second group if not yet known
    assign tot = (second_grp && (i_state.total_parts == 3'd0))
               ? 3'(3'd2 + {1'b0, gsi}) : i_state.total_parts;
    // part number = total - gsi must equal expected + 1
    assign part_sum = {1'b0, i_state.expected_part} + {2'b00, gsi} + 4'd1;

    always_comb begin
        n_st = i_state;
        res  = '0;
        res.event_kind = tmgd_pkg::KIND_IGNORED;
        if (i_func) begin
            case (i_group_c[15:14])
                tmgd_pkg::SYS_VAR_TABLE: begin
                    n_st.table_number   = i_group_c[11:6];
                    n_st.afi_mode_scope = i_group_c[5:0];
                end
                tmgd_pkg::SYS_VAR_SERVICE: begin
                    n_st.service_id = i_group_c[11:6];
                end
                default: begin
                end
            endcase
            res.event_kind = tmgd_pkg::KIND_SYSTEM;
        end else begin
            if (enc_grp) begin
                n_st.service_id             = i_group_c[10:5];
                n_st.encryption_id          = i_group_c[4:0];
                n_st.encrypted_table_number = i_group_d[15:10];
                res.encryption_updated      = 1'b1;
            end
            if (i_group_b[4]) begin
                if (i_group_b[3:0] == tmgd_pkg::TUNE_NAME_FIRST) begin
                    n_st.name_half_mask[0] = 1'b1;
                    res.payload            = {i_group_c, i_group_d};
                    res.event_kind         = tmgd_pkg::KIND_NAME;
                end else if (i_group_b[3:0] == tmgd_pkg::TUNE_NAME_LAST) begin
                    n_st.name_half_mask[1] = 1'b1;
                    res.payload            = {i_group_c, i_group_d};
                    res.event_kind         = tmgd_pkg::KIND_NAME;
                end
            end else if (single_grp || first_grp) begin
                res.direction  = i_group_c[14];
                res.extent     = i_group_c[13:11];
                res.event_code = i_group_c[10:0];
                res.location   = i_group_d;
                if (!single_grp) begin
                    n_st.expected_part    = 3'd1;
                    n_st.continuity_index = ci;
                    n_st.total_parts      = 3'd0;
                    res.event_kind        = tmgd_pkg::KIND_START;
                end else begin
                    res.diversion      = first_grp;
                    res.duration       = ci;
                    n_st.expected_part = 3'd0;
                    res.event_kind     = tmgd_pkg::KIND_SINGLE;
                end
            end else if ((i_state.expected_part != 3'd0) &&
                         (i_state.continuity_index == ci)) begin
                n_st.total_parts = tot;
                if ((tot != 3'd0) && ({1'b0, tot} == part_sum)) begin
                    res.payload = {4'd0, i_group_c[11:0], i_group_d};
                    if (gsi != 2'd0) begin
                        n_st.expected_part = 3'(i_state.expected_part + 3'd1);
                        res.event_kind     = tmgd_pkg::KIND_CONTENT;
                    end else begin
                        n_st.expected_part = 3'd0;
                        res.event_kind     = tmgd_pkg::KIND_FINAL;
                    end
                end
            end else begin
                // stray continuation: drop any reassembly
                n_st.expected_part = 3'd0;
                res.event_kind     = tmgd_pkg::KIND_RESET;
            end
            if (enc_grp && (res.event_kind == tmgd_pkg::KIND_IGNORED)) begin
                res.event_kind = tmgd_pkg::KIND_ENC_ONLY;
            end
        end
        res.name_halves  = n_st.name_half_mask;
        res.service_info = {n_st.table_number, n_st.encrypted_table_number,
                            n_st.service_id, n_st.encryption_id,
                            n_st.afi_mode_scope};
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam logic FUNC_GROUP  = 1'b0;
    localparam logic FUNC_SYSTEM = 1'b1;

    // system variants that carry nothing
    localparam logic [1:0] SYS_VAR_SPARE_A = 2'd2;
    localparam logic [1:0] SYS_VAR_SPARE_B = 2'd3;

    localparam int RANDOM_GROUPS = 1600;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic        func;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
    } t_group;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;

    traffic_message_group_decoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_group            group_backlog[$];
    tmgd_pkg::t_result decoded_results[$];
    int      groups_total;
    int      groups_taken = 0;
    int      results_seen = 0;
    int      fail_cnt = 0;
    logic    rx_hold_off = 1'b0;

    // shadow of the decoder's reassembly and service registers
    logic [2:0] last_part;
    logic [2:0] msg_ci;
    logic [2:0] msg_parts;
    logic [1:0] name_seen;
    logic [5:0] tbl_num;
    logic [5:0] enc_tbl_num;
    logic [5:0] svc_id;
    logic [4:0] enc_id;
    logic [5:0] afi_ms;

    function automatic tmgd_pkg::t_result decode_group(input logic func,
                                                       input logic [15:0] b,
                                                       input logic [15:0] c,
                                                       input logic [15:0] d);
        tmgd_pkg::t_result r;
        logic [1:0] gsi;
        int part;
        r = '0;
        gsi = c[13:12];
        if (func) begin
            if (c[15:14] == tmgd_pkg::SYS_VAR_TABLE) begin
                tbl_num = c[11:6];
                afi_ms = c[5:0];
            end else if (c[15:14] == tmgd_pkg::SYS_VAR_SERVICE) begin
                svc_id = c[11:6];
            end
            r.event_kind = tmgd_pkg::KIND_SYSTEM;
        end else begin
            // encryption admin rides along with whatever else the group does
            if (b[4:0] == 5'd0 && c[15:13] == 3'd0) begin
                svc_id = c[10:5];
                enc_id = c[4:0];
                enc_tbl_num = d[15:10];
                r.encryption_updated = 1'b1;
            end
            if (b[4]) begin
                if (b[3:0] == tmgd_pkg::TUNE_NAME_FIRST ||
                    b[3:0] == tmgd_pkg::TUNE_NAME_LAST) begin
                    name_seen |= (b[3:0] == tmgd_pkg::TUNE_NAME_FIRST) ? 2'b01 : 2'b10;
                    r.payload = {c, d};
                    r.event_kind = tmgd_pkg::KIND_NAME;
                end
            end else if (b[3] || c[15]) begin
                r.direction = c[14];
                r.extent = c[13:11];
                r.event_code = c[10:0];
                r.location = d;
                if (!b[3]) begin
                    last_part = 3'd1;
                    msg_ci = b[2:0];
                    msg_parts = 3'd0;
                    r.event_kind = tmgd_pkg::KIND_START;
                end else begin
                    r.diversion = c[15];
                    r.duration = b[2:0];
                    last_part = 3'd0;
                    r.event_kind = tmgd_pkg::KIND_SINGLE;
                end
            end else if (last_part != 3'd0 && msg_ci == b[2:0]) begin
                if (c[14] && msg_parts == 3'd0)
                    msg_parts = 3'(3'd2 + gsi);
                if (msg_parts != 3'd0) begin
                    part = int'(msg_parts) - int'(gsi);
                    // anything but the next part is a duplicate or a gap
                    if (part == int'(last_part) + 1) begin
                        r.payload = {4'd0, c[11:0], d};
                        if (gsi != 2'd0) begin
                            last_part = last_part + 3'd1;
                            r.event_kind = tmgd_pkg::KIND_CONTENT;
                        end else begin
                            last_part = 3'd0;
                            r.event_kind = tmgd_pkg::KIND_FINAL;
                        end
                    end
                end
            end else begin
                last_part = 3'd0;
                r.event_kind = tmgd_pkg::KIND_RESET;
            end
            if (r.encryption_updated && r.event_kind == tmgd_pkg::KIND_IGNORED)
                r.event_kind = tmgd_pkg::KIND_ENC_ONLY;
        end
        r.name_halves = name_seen;
        r.service_info = {tbl_num, enc_tbl_num, svc_id, enc_id, afi_ms};
        return r;
    endfunction

    function automatic string field_diff(input tmgd_pkg::t_result want,
                                         input tmgd_pkg::t_result got);
        string s;
        s = "";
        if (got.event_kind !== want.event_kind) s = {s, " event_kind"};
        if (got.encryption_updated !== want.encryption_updated) s = {s, " encryption_updated"};
        if (got.diversion !== want.diversion) s = {s, " diversion"};
        if (got.direction !== want.direction) s = {s, " direction"};
        if (got.extent !== want.extent) s = {s, " extent"};
        if (got.event_code !== want.event_code) s = {s, " event_code"};
        if (got.location !== want.location) s = {s, " location"};
        if (got.duration !== want.duration) s = {s, " duration"};
        if (got.payload !== want.payload) s = {s, " payload"};
        if (got.name_halves !== want.name_halves) s = {s, " name_halves"};
        if (got.service_info !== want.service_info) s = {s, " service_info"};
        return s;
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("tb: mismatch %0d: %s", fail_cnt, msg);
    endtask

    task automatic push_group(input logic func, input logic [15:0] b,
                              input logic [15:0] c, input logic [15:0] d);
        group_backlog.insert(group_backlog.size(), '{func: func, b: b, c: c, d: d});
    endtask

    task automatic push_noise();
        push_group(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // multi-group message; a sloppy one gets dropped, doubled or misnumbered parts, or noise before a part
    task automatic queue_message(input logic [2:0] ci, input int parts, input bit sloppy);
        logic [1:0] left;
        logic [15:0] c;
        int k;
        push_group(FUNC_GROUP, {11'($urandom), 2'b00, ci}, {1'b1, 15'($urandom)},
                   16'($urandom));
        for (k = 2; k <= parts; k++) begin
            left = 2'(parts - k);
            c = {1'b0, k == 2, left, 12'($urandom)};
            if (sloppy && $urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: begin
                        push_group(FUNC_GROUP, {11'($urandom), 2'b00, ci}, c, 16'($urandom));
                        push_group(FUNC_GROUP, {11'($urandom), 2'b00, ci}, c, 16'($urandom));
                    end
                    2: push_group(FUNC_GROUP, {11'($urandom), 2'b00, 3'(ci + 3'd1)}, c,
                                  16'($urandom));
                    default: begin
                        push_noise();
                        push_group(FUNC_GROUP, {11'($urandom), 2'b00, ci}, c, 16'($urandom));
                    end
                endcase
            end else begin
                push_group(FUNC_GROUP, {11'($urandom), 2'b00, ci}, c, 16'($urandom));
            end
        end
    endtask

    task automatic build_stimulus();
        int pick;
        int goal;
        // system words: both writable variants at their extremes, then the inert ones
        push_group(FUNC_SYSTEM, 16'hFFFF, {tmgd_pkg::SYS_VAR_TABLE, 14'h3FFF}, 16'hFFFF);
        push_group(FUNC_SYSTEM, 16'h0000, {tmgd_pkg::SYS_VAR_TABLE, 14'h0000}, 16'h0000);
        push_group(FUNC_SYSTEM, 16'h0000, {tmgd_pkg::SYS_VAR_SERVICE, 14'h3FFF}, 16'h0000);
        push_group(FUNC_SYSTEM, 16'h1234, {SYS_VAR_SPARE_A, 14'h2AAA}, 16'h5678);
        push_group(FUNC_SYSTEM, 16'hFFFF, {SYS_VAR_SPARE_B, 14'h3FFF}, 16'hFFFF);
        // encryption admin at the extremes; also a stray continuation on ci 0
        push_group(FUNC_GROUP, 16'hFFE0, 16'h1FFF, 16'hFFFF);
        push_group(FUNC_GROUP, 16'h0000, 16'h0000, 16'h0000);
        // provider name halves, and tuning addresses that are not names
        push_group(FUNC_GROUP, {11'h7FF, 1'b1, tmgd_pkg::TUNE_NAME_FIRST}, 16'hFFFF, 16'hFFFF);
        push_group(FUNC_GROUP, {11'h000, 1'b1, tmgd_pkg::TUNE_NAME_LAST}, 16'h0000, 16'h0000);
        push_group(FUNC_GROUP, {11'h000, 1'b1, 4'hF}, 16'hABCD, 16'hEF01);
        push_group(FUNC_GROUP, {11'h7FF, 1'b1, 4'h0}, 16'h1FFF, 16'h0000);
        // single-group messages
        push_group(FUNC_GROUP, 16'hFFEF, 16'hFFFF, 16'hFFFF);
        push_group(FUNC_GROUP, 16'h0008, 16'h0000, 16'h0000);
        // start on ci 0, then an encryption group that is a continuation
        // with the part count unknown: dropped, so encryption only
        push_group(FUNC_GROUP, 16'h0000, 16'h8000, 16'h0000);
        push_group(FUNC_GROUP, 16'h0000, 16'h0ABC, 16'h1234);
        // four parts on ci 5 with a duplicated part and the last part sent early once
        push_group(FUNC_GROUP, 16'h0005, 16'hC7FF, 16'hFFFF);
        push_group(FUNC_GROUP, 16'h0005, 16'h6FFF, 16'hFFFF);
        push_group(FUNC_GROUP, 16'h0005, 16'h6FFF, 16'hFFFF);
        push_group(FUNC_GROUP, 16'h0005, 16'h0123, 16'h4567);
        push_group(FUNC_GROUP, 16'h0005, 16'h1000, 16'h0000);
        push_group(FUNC_GROUP, 16'h0005, 16'h0FFF, 16'hFFFF);
        // continuation with nothing in progress
        push_group(FUNC_GROUP, 16'h0003, 16'h1234, 16'h5678);
        // five parts on ci 7, broken by a foreign continuity index
        push_group(FUNC_GROUP, 16'h0007, 16'h8000, 16'h0000);
        push_group(FUNC_GROUP, 16'h0007, 16'h7000, 16'h0001);
        push_group(FUNC_GROUP, 16'h0006, 16'h2000, 16'h0002);
        push_group(FUNC_GROUP, 16'h0007, 16'h2000, 16'h0003);

        goal = group_backlog.size() + RANDOM_GROUPS;
        while (group_backlog.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_message(3'($urandom), $urandom_range(2, 5), $urandom_range(0, 2) == 0);
            else if (pick < 58)
                push_group(FUNC_GROUP, {11'($urandom), 2'b01, 3'($urandom)}, 16'($urandom),
                           16'($urandom));
            else if (pick < 68)
                push_group(FUNC_GROUP, {11'($urandom), 1'b1,
                           $urandom_range(0, 5) == 0 ? 4'($urandom) :
                           ($urandom_range(0, 1) ? tmgd_pkg::TUNE_NAME_FIRST :
                                                   tmgd_pkg::TUNE_NAME_LAST)},
                           16'($urandom), 16'($urandom));
            else if (pick < 78)
                push_group(FUNC_SYSTEM, 16'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 87)
                push_group(FUNC_GROUP, {11'($urandom), 5'd0}, {3'd0, 13'($urandom)},
                           16'($urandom));
            else
                push_noise();
        end
        groups_total = group_backlog.size();
    endtask

    // sender: bursts of random length, random gaps in between
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive
        t_group g;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decoded_results.insert(decoded_results.size(),
                                       decode_group(s_axis_tuser, s_axis_tdata[15:0],
                                                    s_axis_tdata[31:16],
                                                    s_axis_tdata[47:32]));
                groups_taken++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (group_backlog.size() != 0) begin
                    g = group_backlog.pop_front();
                    s_axis_tdata <= {g.d, g.c, g.b};
                    s_axis_tuser <= g.func;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 9) == 0) begin
                            burst_left = $urandom_range(60, 150);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                        end
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern in one of four modes, picked anew at random
    t_rx_mode rx_mode = RX_OPEN;
    int rx_phase_left = 0;
    int rx_tick = 0;

    always @(posedge i_clk) begin : receive
        logic rdy;
        rdy = 1'b1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_phase_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(16, 96);
            end else begin
                rx_phase_left--;
            end
            case (rx_mode)
                RX_OPEN:     rdy = 1'b1;
                RX_COIN:     rdy = $urandom_range(0, 1) == 1;
                RX_SPARSE:   rdy = $urandom_range(0, 3) == 0;
                RX_PERIODIC: rdy = (rx_tick % 3) != 0;
                default:     rdy = 1'b1;
            endcase
            m_axis_tready <= rdy && !rx_hold_off;
        end
    end

    // long hold-off while the sender keeps offering, so the input side backs up
    initial begin : hold_off
        while (results_seen < 500)
            @(posedge i_clk);
        rx_hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        rx_hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin : watch
        tmgd_pkg::t_result got;
        tmgd_pkg::t_result want;
        string bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.event_kind = tmgd_pkg::t_kind'(m_axis_tuser);
            got.encryption_updated = m_axis_tdata[0];
            got.diversion = m_axis_tdata[1];
            got.direction = m_axis_tdata[2];
            got.extent = m_axis_tdata[5:3];
            got.event_code = m_axis_tdata[16:6];
            got.location = m_axis_tdata[32:17];
            got.duration = m_axis_tdata[35:33];
            got.payload = m_axis_tdata[67:36];
            got.name_halves = m_axis_tdata[69:68];
            got.service_info = m_axis_tdata[98:70];
            if (decoded_results.size() == 0) begin
                note_failure($sformatf("result %0d with none expected: %p", results_seen, got));
            end else begin
                want = decoded_results.pop_front();
                bad = field_diff(want, got);
                if (bad != "")
                    note_failure($sformatf("result %0d fields%s\n  exp %p\n  act %p",
                                           results_seen, bad, want, got));
            end
        end
    end

    initial begin : limit
        #3_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin : main
        last_part = '0;
        msg_ci = '0;
        msg_parts = '0;
        name_seen = '0;
        tbl_num = '0;
        enc_tbl_num = '0;
        svc_id = '0;
        enc_id = '0;
        afi_ms = '0;
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (groups_taken < groups_total || decoded_results.size() != 0)
            @(posedge i_clk);
        // two-stage pipe: give a stray extra result room to show up
        repeat (10) @(posedge i_clk);
        if (decoded_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", decoded_results.size()));
        if (fail_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
